### rtl/core/i2c_ram_pkg.sv
// Shared types and codes for the I2C register access master.
// Used by the sequencer, the top level and the port checker; no dependencies.
package i2c_ram_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_NO_ACK  = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        P_IDLE       = 4'd0,
        P_START      = 4'd1,
        P_DEV_SEND   = 4'd2,
        P_DEV_ACK    = 4'd3,
        P_REG_SEND   = 4'd4,
        P_REG_ACK    = 4'd5,
        P_DATA_SEND  = 4'd6,
        P_DATA_ACK   = 4'd7,
        P_RSTART     = 4'd8,
        P_RADDR_SEND = 4'd9,
        P_RADDR_ACK  = 4'd10,
        P_RECV       = 4'd11,
        P_RACK       = 4'd12,
        P_STOP       = 4'd13,
        P_STOP_FAIL  = 4'd14
    } phase_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  dev_addr;
        logic [10:0] reg_addr;
        logic [7:0]  wdata;
        logic [15:0] read_len;
        logic        sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] rdata;
        logic       rdata_valid;
        logic       last_byte;
        logic       done_res;
        logic [1:0] status;
        logic       busy_res;
    } result_t;

endpackage

### rtl/core/i2c_ram_seq.sv
// Bus sequencer: transaction state registers and the one-step next-state logic.
// Depends on i2c_ram_pkg.
module i2c_ram_seq
    import i2c_ram_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t res
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  sub_reg, sub_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  dev_addr_reg, dev_addr_next;
    logic [10:0] reg_addr_reg, reg_addr_next;
    logic [7:0]  wdata_reg, wdata_next;
    logic        is_read_reg, is_read_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= P_IDLE;
            sub_reg        <= '0;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            bytes_left_reg <= '0;
            dev_addr_reg   <= '0;
            reg_addr_reg   <= '0;
            wdata_reg      <= '0;
            is_read_reg    <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            sub_reg        <= sub_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            dev_addr_reg   <= dev_addr_next;
            reg_addr_reg   <= reg_addr_next;
            wdata_reg      <= wdata_next;
            is_read_reg    <= is_read_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
        end
    end

    logic        scl_v;
    logic        sda_v;
    logic        lower;
    logic        release_lines;
    logic [15:0] left_dec;

    assign left_dec = bytes_left_reg - 16'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        sub_next        = sub_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        dev_addr_next   = dev_addr_reg;
        reg_addr_next   = reg_addr_reg;
        wdata_next      = wdata_reg;
        is_read_next    = is_read_reg;
        scl_v           = scl_reg;
        sda_v           = sda_reg;
        lower           = 1'b0;
        release_lines   = 1'b0;
        res             = '0;

        if (item.func == FUNC_WRITE || item.func == FUNC_READ)
        begin
            // commands are dropped while a transaction runs
            if (phase_reg == P_IDLE)
            begin
                dev_addr_next   = item.dev_addr;
                reg_addr_next   = item.reg_addr;
                wdata_next      = item.wdata;
                bytes_left_next = item.read_len;
                is_read_next    = (item.func == FUNC_READ);
                phase_next      = P_START;
                sub_next        = '0;
                bit_cnt_next    = '0;
            end
        end
        else
        begin
            case (phase_reg)
                P_IDLE:
                begin
                end
                P_START, P_RSTART:
                begin
                    if (sub_reg == 2'd0)
                    begin
                        scl_v = 1'b1;
                        sda_v = 1'b1;
                        if (phase_reg == P_START && !item.sda_in)
                        begin
                            res.status = ST_BUSY;
                        end
                        sub_next = 2'd1;
                    end
                    else if (sub_reg == 2'd1)
                    begin
                        sda_v = 1'b0;
                        if (phase_reg == P_START && item.sda_in)
                        begin
                            res.status = ST_ERROR;
                        end
                        sub_next = 2'd2;
                    end
                    else
                    begin
                        sda_v        = 1'b0;
                        sub_next     = '0;
                        bit_cnt_next = '0;
                        if (phase_reg == P_START)
                        begin
                            phase_next = P_DEV_SEND;
                            shift_next = dev_addr_reg;
                        end
                        else
                        begin
                            phase_next = P_RADDR_SEND;
                            shift_next = {4'd0, reg_addr_reg[10:8], 1'b0} | dev_addr_reg
                                         | 8'h01;
                        end
                    end
                    // bad line level at start: abort without stop
                    if (res.status != ST_OK)
                    begin
                        res.done_res  = 1'b1;
                        release_lines = 1'b1;
                        phase_next    = P_IDLE;
                        sub_next      = '0;
                        bit_cnt_next  = '0;
                    end
                end
                P_DEV_SEND, P_REG_SEND, P_DATA_SEND, P_RADDR_SEND:
                begin
                    if (bit_cnt_reg >= BITS_PER_BYTE)
                    begin
                        scl_v        = 1'b0;
                        sub_next     = '0;
                        bit_cnt_next = '0;
                        case (phase_reg)
                            P_DEV_SEND:  phase_next = P_DEV_ACK;
                            P_REG_SEND:  phase_next = P_REG_ACK;
                            P_DATA_SEND: phase_next = P_DATA_ACK;
                            default:     phase_next = P_RADDR_ACK;
                        endcase
                    end
                    else if (sub_reg == 2'd0)
                    begin
                        scl_v    = 1'b0;
                        sub_next = 2'd1;
                    end
                    else if (sub_reg == 2'd1)
                    begin
                        sda_v      = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        sub_next   = 2'd2;
                    end
                    else
                    begin
                        scl_v        = 1'b1;
                        sub_next     = '0;
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                    end
                end
                P_DEV_ACK, P_REG_ACK, P_DATA_ACK, P_RADDR_ACK:
                begin
                    if (sub_reg == 2'd0)
                    begin
                        scl_v    = 1'b0;
                        sub_next = 2'd1;
                    end
                    else if (sub_reg == 2'd1)
                    begin
                        sda_v    = 1'b1;
                        sub_next = 2'd2;
                    end
                    else
                    begin
                        scl_v        = 1'b1;
                        lower        = 1'b1;
                        sub_next     = '0;
                        bit_cnt_next = '0;
                        case (phase_reg)
                            P_DEV_ACK:
                            begin
                                if (item.sda_in)
                                begin
                                    phase_next = P_STOP_FAIL;
                                end
                                else
                                begin
                                    phase_next = P_REG_SEND;
                                    shift_next = reg_addr_reg[7:0];
                                end
                            end
                            P_REG_ACK:
                            begin
                                if (is_read_reg)
                                begin
                                    phase_next = P_RSTART;
                                end
                                else
                                begin
                                    phase_next = P_DATA_SEND;
                                    shift_next = wdata_reg;
                                end
                            end
                            P_DATA_ACK:
                            begin
                                phase_next = P_STOP;
                            end
                            default:
                            begin
                                phase_next = (bytes_left_reg != 16'd0) ? P_RECV : P_STOP;
                            end
                        endcase
                    end
                end
                P_RECV:
                begin
                    if (sub_reg == 2'd0)
                    begin
                        if (bit_cnt_reg == 4'd0)
                        begin
                            sda_v = 1'b1;
                        end
                        scl_v    = 1'b0;
                        sub_next = 2'd1;
                    end
                    else
                    begin
                        scl_v        = 1'b1;
                        shift_next   = {shift_reg[6:0], item.sda_in};
                        sub_next     = '0;
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        if (bit_cnt_next >= BITS_PER_BYTE)
                        begin
                            bit_cnt_next    = '0;
                            lower           = 1'b1;
                            res.rdata_valid = 1'b1;
                            res.rdata       = shift_next;
                            res.last_byte   = (bytes_left_reg == 16'd1);
                            phase_next      = P_RACK;
                        end
                    end
                end
                P_RACK:
                begin
                    case (sub_reg)
                        2'd0:
                        begin
                            scl_v    = 1'b0;
                            sub_next = 2'd1;
                        end
                        2'd1:
                        begin
                            // no-ack after the last byte
                            sda_v    = (bytes_left_reg == 16'd1);
                            sub_next = 2'd2;
                        end
                        2'd2:
                        begin
                            scl_v    = 1'b1;
                            sub_next = 2'd3;
                        end
                        default:
                        begin
                            scl_v           = 1'b0;
                            sub_next        = '0;
                            bit_cnt_next    = '0;
                            bytes_left_next = left_dec;
                            phase_next      = (left_dec != 16'd0) ? P_RECV : P_STOP;
                        end
                    endcase
                end
                P_STOP, P_STOP_FAIL:
                begin
                    case (sub_reg)
                        2'd0:
                        begin
                            scl_v    = 1'b0;
                            sub_next = 2'd1;
                        end
                        2'd1:
                        begin
                            sda_v    = 1'b0;
                            sub_next = 2'd2;
                        end
                        2'd2:
                        begin
                            scl_v    = 1'b1;
                            sub_next = 2'd3;
                        end
                        default:
                        begin
                            sda_v        = 1'b1;
                            sub_next     = '0;
                            bit_cnt_next = '0;
                            res.done_res = 1'b1;
                            res.status   = (phase_reg == P_STOP_FAIL) ? ST_NO_ACK : ST_OK;
                            phase_next   = P_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    phase_next   = P_IDLE;
                    sub_next     = '0;
                    bit_cnt_next = '0;
                end
            endcase
        end

        // lines are shown as driven during the item, before the trailing SCL drop
        res.scl_out  = scl_v;
        res.sda_out  = sda_v;
        res.busy_res = (phase_next != P_IDLE);
        scl_next     = release_lines ? 1'b1 : (lower ? 1'b0 : scl_v);
        sda_next     = release_lines ? 1'b1 : sda_v;
    end

endmodule

### rtl/core/i2c_register_access_master.sv
// Top level of the I2C register access master: input stage, sequencer, result stage.
// Depends on i2c_ram_pkg and i2c_ram_seq.
//
// Each item is a command (start write, start read) or a tick of one bus delay period
// carrying the sampled SDA level; every item yields exactly one result with the SCL and
// SDA drive for that period, any received byte and the transaction status. One item is
// taken per clock cycle unless out_ready stalls the result stage; an item passes the
// input register, the combinational sequencer step and then the result register. Input
// ready stays high while the input register is empty or the result register is free
// or being emptied in the same cycle.
module i2c_register_access_master
    import i2c_ram_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  dev_addr,
    input  logic [10:0] reg_addr,
    input  logic [7:0]  wdata,
    input  logic [15:0] read_len,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_out,
    output logic        sda_out,
    output logic [7:0]  rdata,
    output logic        rdata_valid,
    output logic        last_byte,
    output logic        done_res,
    output logic [1:0]  status,
    output logic        busy_res
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= '{func: func, dev_addr: dev_addr, reg_addr: reg_addr,
                             wdata: wdata, read_len: read_len, sda_in: sda_in};
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    i2c_ram_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .res   (step_res)
    );

    assign out_valid   = out_valid_reg;
    assign scl_out     = out_res_reg.scl_out;
    assign sda_out     = out_res_reg.sda_out;
    assign rdata       = out_res_reg.rdata;
    assign rdata_valid = out_res_reg.rdata_valid;
    assign last_byte   = out_res_reg.last_byte;
    assign done_res    = out_res_reg.done_res;
    assign status      = out_res_reg.status;
    assign busy_res    = out_res_reg.busy_res;

endmodule

### rtl/core/i2c_ram_chk.sv
// Port-level checker for the I2C register access master, bound to the top level.
// Depends on i2c_ram_pkg.
module i2c_ram_chk
    import i2c_ram_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       scl_out,
    input logic       sda_out,
    input logic [7:0] rdata,
    input logic       rdata_valid,
    input logic       last_byte,
    input logic       done_res,
    input logic [1:0] status,
    input logic       busy_res
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rdata) && $stable(status)
            && $stable(scl_out) && $stable(sda_out))
        else $error("result item changed while stalled");

    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rdata_valid |-> rdata == 8'd0 && !last_byte)
        else $error("byte fields set without a received byte");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == ST_OK)
        else $error("status reported without completion");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && !rdata_valid)
        else $error("completed transaction still busy");

    a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rdata_valid |-> busy_res && scl_out)
        else $error("received byte outside a running read");

endmodule

bind i2c_register_access_master i2c_ram_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .scl_out     (scl_out),
    .sda_out     (sda_out),
    .rdata       (rdata),
    .rdata_valid (rdata_valid),
    .last_byte   (last_byte),
    .done_res    (done_res),
    .status      (status),
    .busy_res    (busy_res)
);
